// ===== hw/rtl/hsp_pkg.sv =====
// hsp_pkg: shared types and constants for the hmac-sha1 price decryption block
// controller state and register index enums, command and status structs, sha-1 and length constants
// no dependencies
`default_nettype none
package hsp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_ENC_W0,
		REG_ENC_W1,
		REG_ENC_W2,
		REG_ENC_W3,
		REG_INT_W0,
		REG_INT_W1,
		REG_INT_W2,
		REG_INT_W3
	} reg_idx_t;

	typedef struct packed {
		logic       capture;
		logic       load;
		logic       step;
		logic       finish;
		logic       emit;
		logic [2:0] blk;
		logic [1:0] stage;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

	localparam logic [2:0] LAST_BLK   = 3'd7;
	localparam logic [6:0] LAST_ROUND = 7'd79;

	localparam logic [31:0] H0_0 = 32'h67452301;
	localparam logic [31:0] H0_1 = 32'hEFCDAB89;
	localparam logic [31:0] H0_2 = 32'h98BADCFE;
	localparam logic [31:0] H0_3 = 32'h10325476;
	localparam logic [31:0] H0_4 = 32'hC3D2E1F0;

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	localparam logic [63:0] LEN_IV   = 64'd640;
	localparam logic [63:0] LEN_DIG  = 64'd672;
	localparam logic [63:0] LEN_MSG  = 64'd704;

endpackage
`default_nettype wire

// ===== hw/rtl/hsp_ctrl.sv =====
// hsp_ctrl: sequencer for the eight sha-1 compressions of one token
// depends on hsp_pkg
`default_nettype none
module hsp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire hsp_pkg::stat_t stat,
	output hsp_pkg::cmd_t       cmd
);

	hsp_pkg::state_t state_q, state_d;
	logic [2:0] blk_q, blk_d;
	logic [6:0] rnd_q, rnd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsp_pkg::ST_IDLE;
			blk_q   <= '0;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			blk_q   <= blk_d;
			rnd_q   <= rnd_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		blk_d       = blk_q;
		rnd_d       = rnd_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.blk     = blk_q;
		if (rnd_q < 7'd20)
			cmd.stage = 2'd0;
		else if (rnd_q < 7'd40)
			cmd.stage = 2'd1;
		else if (rnd_q < 7'd60)
			cmd.stage = 2'd2;
		else
			cmd.stage = 2'd3;
		case (state_q)
			hsp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					blk_d       = '0;
					state_d     = hsp_pkg::ST_LOAD;
				end
			end
			hsp_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				rnd_d    = '0;
				state_d  = hsp_pkg::ST_ROUND;
			end
			hsp_pkg::ST_ROUND: begin
				cmd.step = 1'b1;
				rnd_d    = rnd_q + 7'd1;
				if (rnd_q == hsp_pkg::LAST_ROUND)
					state_d = hsp_pkg::ST_FINISH;
			end
			hsp_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				if (blk_q == hsp_pkg::LAST_BLK) begin
					state_d = hsp_pkg::ST_OUT;
				end else begin
					blk_d   = blk_q + 3'd1;
					state_d = hsp_pkg::ST_LOAD;
				end
			end
			hsp_pkg::ST_OUT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = hsp_pkg::ST_IDLE;
				end
			end
			default: state_d = hsp_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/hsp_datapath.sv =====
// hsp_datapath: key registers, sha-1 round unit, message schedule and result registers
// depends on hsp_pkg
`default_nettype none
module hsp_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [63:0]          cfg_data,
	input  wire logic [63:0]          iv_high,
	input  wire logic [63:0]          iv_low,
	input  wire logic [63:0]          cipher_word,
	input  wire logic [31:0]          tag_bytes,
	input  wire hsp_pkg::cmd_t        cmd,
	output hsp_pkg::stat_t            stat,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [63:0]        plain_value,
	output logic                      tag_ok
);

	logic [63:0] ek_q [4];
	logic [63:0] ik_q [4];
	logic [63:0] ivh_q, ivl_q, ct_q, plain_q;
	logic [31:0] sig_q;
	logic        ok_q;
	logic [159:0] inner_q;
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];

	logic [255:0] key;
	logic [511:0] blk;
	logic [31:0]  f, k, t, wn;
	logic [31:0]  hn [5];
	logic         init;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				ek_q[i] <= '0;
				ik_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				hsp_pkg::REG_ENC_W0: ek_q[0] <= cfg_data;
				hsp_pkg::REG_ENC_W1: ek_q[1] <= cfg_data;
				hsp_pkg::REG_ENC_W2: ek_q[2] <= cfg_data;
				hsp_pkg::REG_ENC_W3: ek_q[3] <= cfg_data;
				hsp_pkg::REG_INT_W0: ik_q[0] <= cfg_data;
				hsp_pkg::REG_INT_W1: ik_q[1] <= cfg_data;
				hsp_pkg::REG_INT_W2: ik_q[2] <= cfg_data;
				hsp_pkg::REG_INT_W3: ik_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign init = ~cmd.blk[0];

	always_comb begin
		if (cmd.blk[2])
			key = {ik_q[0], ik_q[1], ik_q[2], ik_q[3]};
		else
			key = {ek_q[0], ek_q[1], ek_q[2], ek_q[3]};
		case (cmd.blk)
			3'd0, 3'd4: blk = {key ^ {32{8'h36}}, {32{8'h36}}};
			3'd2, 3'd6: blk = {key ^ {32{8'h5C}}, {32{8'h5C}}};
			3'd1:       blk = {ivh_q, ivl_q, 8'h80, 312'd0, hsp_pkg::LEN_IV};
			3'd5:       blk = {plain_q, ivh_q, ivl_q, 8'h80, 248'd0, hsp_pkg::LEN_MSG};
			default:    blk = {inner_q, 8'h80, 280'd0, hsp_pkg::LEN_DIG};
		endcase
	end

	always_comb begin
		case (cmd.stage)
			2'd0: begin
				f = (b_q & c_q) | (~b_q & d_q);
				k = hsp_pkg::K_0;
			end
			2'd1: begin
				f = b_q ^ c_q ^ d_q;
				k = hsp_pkg::K_1;
			end
			2'd2: begin
				f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k = hsp_pkg::K_2;
			end
			default: begin
				f = b_q ^ c_q ^ d_q;
				k = hsp_pkg::K_3;
			end
		endcase
		t  = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		wn = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wn = {wn[30:0], wn[31]};
		hn[0] = h_q[0] + a_q;
		hn[1] = h_q[1] + b_q;
		hn[2] = h_q[2] + c_q;
		hn[3] = h_q[3] + d_q;
		hn[4] = h_q[4] + e_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ivh_q <= iv_high;
			ivl_q <= iv_low;
			ct_q  <= cipher_word;
			sig_q <= tag_bytes;
		end
		if (cmd.load) begin
			for (int j = 0; j < 16; j++)
				w_q[j] <= blk[511 - 32 * j -: 32];
			if (init) begin
				h_q[0] <= hsp_pkg::H0_0;
				h_q[1] <= hsp_pkg::H0_1;
				h_q[2] <= hsp_pkg::H0_2;
				h_q[3] <= hsp_pkg::H0_3;
				h_q[4] <= hsp_pkg::H0_4;
				a_q    <= hsp_pkg::H0_0;
				b_q    <= hsp_pkg::H0_1;
				c_q    <= hsp_pkg::H0_2;
				d_q    <= hsp_pkg::H0_3;
				e_q    <= hsp_pkg::H0_4;
			end else begin
				a_q <= h_q[0];
				b_q <= h_q[1];
				c_q <= h_q[2];
				d_q <= h_q[3];
				e_q <= h_q[4];
			end
		end
		if (cmd.step) begin
			for (int j = 0; j < 15; j++)
				w_q[j] <= w_q[j + 1];
			w_q[15] <= wn;
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.finish) begin
			for (int i = 0; i < 5; i++)
				h_q[i] <= hn[i];
			if (!cmd.blk[1])
				inner_q <= {hn[0], hn[1], hn[2], hn[3], hn[4]};
			if (cmd.blk == 3'd3)
				plain_q <= {hn[0], hn[1]} ^ ct_q;
			if (cmd.blk == hsp_pkg::LAST_BLK)
				ok_q <= (hn[0] == sig_q);
		end
		if (cmd.emit) begin
			plain_value <= plain_q;
			tag_ok      <= ok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.emit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	assign stat.out_busy = out_valid & ~out_ready;

endmodule
`default_nettype wire

// ===== hw/rtl/hmac_sha1_price_decrypt.sv =====
// hmac_sha1_price_decrypt: top level, hmac-sha1 token decryption and signature check
// depends on hsp_pkg, hsp_ctrl, hsp_datapath
//
// channel  handshake              payload
// input    in_valid / in_ready    iv_high, iv_low, cipher_word, tag_bytes
// output   out_valid / out_ready  plain_value, tag_ok
// config   cfg_we                 cfg_index, cfg_data
//
// one beat takes 8 sha-1 compressions on a single round unit; a new beat is taken
// once the result is handed to the output register. reset clears control and the
// key registers.
// a stalled output holds the finished token in its final state until taken.
`default_nettype none
module hmac_sha1_price_decrypt (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [63:0]   cfg_data,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [63:0]   iv_high,
	input  wire logic [63:0]   iv_low,
	input  wire logic [63:0]   cipher_word,
	input  wire logic [31:0]   tag_bytes,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic signed [63:0] plain_value,
	output logic               tag_ok
);

	hsp_pkg::cmd_t  cmd;
	hsp_pkg::stat_t stat;

	hsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hsp_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.iv_high     (iv_high),
		.iv_low      (iv_low),
		.cipher_word (cipher_word),
		.tag_bytes   (tag_bytes),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.plain_value (plain_value),
		.tag_ok      (tag_ok)
	);

endmodule
`default_nettype wire

// ===== dv/hmac_sha1_price_decrypt_test.sv =====
// hmac_sha1_price_decrypt_test: self-checking bench for the hmac-sha1 price decryption block
// holds its own hmac-sha1 model in a small scoreboard class; stimulus and checks run on beats
// depends on hsp_pkg and hmac_sha1_price_decrypt
module hmac_sha1_price_decrypt_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [63:0] plain;
		bit                 ok;
	} price_t;

	class price_board;
		bit [63:0] key_word[8];
		price_t    due[$];
		int        errors;
		int        checked;
		int        good_tags;

		function bit [31:0] rol(bit [31:0] x, int n);
			return (x << n) | (x >> (32 - n));
		endfunction

		function bit [159:0] sha1_of(bit [7:0] m[128], int len);
			bit [7:0]  b[128];
			bit [31:0] h[5];
			bit [31:0] w[80];
			bit [31:0] a, bb, c, d, e, f, k, t;
			bit [63:0] bits;
			int        nblk;
			b = '{default: 0};
			for (int i = 0; i < len; i++) b[i] = m[i];
			b[len] = 8'h80;
			nblk = (len + 9 + 63) / 64;
			bits = 64'(len) * 64'd8;
			for (int i = 0; i < 8; i++) b[nblk * 64 - 8 + i] = bits[63 - 8 * i -: 8];
			h = '{hsp_pkg::H0_0, hsp_pkg::H0_1, hsp_pkg::H0_2, hsp_pkg::H0_3, hsp_pkg::H0_4};
			for (int n = 0; n < nblk; n++) begin
				for (int i = 0; i < 16; i++)
					w[i] = {b[n*64+4*i], b[n*64+4*i+1], b[n*64+4*i+2], b[n*64+4*i+3]};
				for (int i = 16; i < 80; i++)
					w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
				a = h[0]; bb = h[1]; c = h[2]; d = h[3]; e = h[4];
				for (int i = 0; i < 80; i++) begin
					if (i < 20) begin
						f = (bb & c) | (~bb & d); k = hsp_pkg::K_0;
					end else if (i < 40) begin
						f = bb ^ c ^ d; k = hsp_pkg::K_1;
					end else if (i < 60) begin
						f = (bb & c) | (bb & d) | (c & d); k = hsp_pkg::K_2;
					end else begin
						f = bb ^ c ^ d; k = hsp_pkg::K_3;
					end
					t = rol(a, 5) + f + e + k + w[i];
					e = d; d = c; c = rol(bb, 30); bb = a; a = t;
				end
				h[0] += a; h[1] += bb; h[2] += c; h[3] += d; h[4] += e;
			end
			return {h[0], h[1], h[2], h[3], h[4]};
		endfunction

		function bit [159:0] hmac(bit [255:0] key, bit [7:0] msg[24], int mlen);
			bit [7:0]   ib[128];
			bit [7:0]   ob[128];
			bit [7:0]   kb;
			bit [159:0] inner;
			ib = '{default: 0};
			ob = '{default: 0};
			for (int i = 0; i < 64; i++) begin
				kb = (i < 32) ? key[255 - 8 * i -: 8] : 8'h00;
				ib[i] = kb ^ 8'h36;
				ob[i] = kb ^ 8'h5c;
			end
			for (int i = 0; i < mlen; i++) ib[64 + i] = msg[i];
			inner = sha1_of(ib, 64 + mlen);
			for (int i = 0; i < 20; i++) ob[64 + i] = inner[159 - 8 * i -: 8];
			return sha1_of(ob, 84);
		endfunction

		function void set_key(hsp_pkg::reg_idx_t idx, bit [63:0] v);
			key_word[idx] = v;
		endfunction

		// pad word from the encryption hmac, and the integrity tag over plain || iv
		function void derive(bit [63:0] ivh, bit [63:0] ivl, bit [63:0] plain,
				output bit [63:0] pad, output bit [31:0] sig);
			bit [7:0]   m[24];
			bit [159:0] d;
			m = '{default: 0};
			for (int i = 0; i < 8; i++) begin
				m[i] = ivh[63 - 8 * i -: 8];
				m[8 + i] = ivl[63 - 8 * i -: 8];
			end
			d = hmac({key_word[0], key_word[1], key_word[2], key_word[3]}, m, 16);
			pad = d[159:96];
			for (int i = 0; i < 8; i++) begin
				m[i] = plain[63 - 8 * i -: 8];
				m[8 + i] = ivh[63 - 8 * i -: 8];
				m[16 + i] = ivl[63 - 8 * i -: 8];
			end
			d = hmac({key_word[4], key_word[5], key_word[6], key_word[7]}, m, 24);
			sig = d[159:128];
		endfunction

		function void note(bit [63:0] ivh, bit [63:0] ivl, bit [63:0] cw, bit [31:0] tb);
			bit [63:0] pad, p;
			bit [31:0] sig;
			price_t    x;
			derive(ivh, ivl, 64'h0, pad, sig);
			p = pad ^ cw;
			derive(ivh, ivl, p, pad, sig);
			x.plain = p;
			x.ok = (sig == tb);
			due.push_back(x);
		endfunction

		function void check(logic signed [63:0] pv, logic ok);
			price_t x;
			if (due.size() == 0) begin
				$display("%0t: result with nothing pending: plain %h ok %b", $time, pv, ok);
				errors++;
				return;
			end
			x = due.pop_front();
			checked++;
			if (x.ok) good_tags++;
			if (pv !== x.plain) begin
				$display("%0t: plain_value expected %h actual %h", $time, x.plain, pv);
				errors++;
			end
			if (ok !== x.ok) begin
				$display("%0t: tag_ok expected %b actual %b", $time, x.ok, ok);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [63:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [63:0]        iv_high;
	logic [63:0]        iv_low;
	logic [63:0]        cipher_word;
	logic [31:0]        tag_bytes;
	logic               out_valid;
	logic               out_ready;
	logic signed [63:0] plain_value;
	logic               tag_ok;

	price_board board;
	bit         rx_hold;

	hmac_sha1_price_decrypt dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.iv_high(iv_high), .iv_low(iv_low), .cipher_word(cipher_word), .tag_bytes(tag_bytes),
		.out_valid(out_valid), .out_ready(out_ready),
		.plain_value(plain_value), .tag_ok(tag_ok)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("timeout with %0d results pending", board.due.size());
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note(iv_high, iv_low, cipher_word, tag_bytes);
		if (arst_n && out_valid && out_ready)
			board.check(plain_value, tag_ok);
	end

	function int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
		return $urandom_range(1, 4);
	endfunction

	// receiver back-pressure, with stretches of no stalling
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold || $urandom_range(0, 2) == 0) begin
				out_ready = 1'b1;
				n = rx_hold ? 1 : $urandom_range(1, 400);
				repeat (n) @(negedge clk);
			end else begin
				out_ready = 1'b0;
				n = gap_len();
				repeat (n) @(negedge clk);
			end
		end
	end

	task automatic write_reg(hsp_pkg::reg_idx_t idx, bit [63:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		board.set_key(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_keys(bit [255:0] ek, bit [255:0] ik);
		for (int i = 0; i < 4; i++) begin
			write_reg(hsp_pkg::reg_idx_t'(hsp_pkg::REG_ENC_W0 + i), ek[255 - 64 * i -: 64]);
			write_reg(hsp_pkg::reg_idx_t'(hsp_pkg::REG_INT_W0 + i), ik[255 - 64 * i -: 64]);
		end
	endtask

	task automatic send(bit [63:0] ivh, bit [63:0] ivl, bit [63:0] cw, bit [31:0] tb, int gap);
		repeat (gap) @(negedge clk);
		in_valid = 1'b1;
		iv_high = ivh;
		iv_low = ivl;
		cipher_word = cw;
		tag_bytes = tb;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// token built from a chosen price, optionally spoiled in cipher or signature
	task automatic send_price(bit [63:0] ivh, bit [63:0] ivl, bit [63:0] p, int spoil, int gap);
		bit [63:0] pad;
		bit [31:0] sig;
		board.derive(ivh, ivl, p, pad, sig);
		if (spoil == 1) sig ^= 32'h1 << $urandom_range(0, 31);
		if (spoil == 2) p ^= 64'h1 << $urandom_range(0, 63);
		send(ivh, ivl, pad ^ p, sig, gap);
	endtask

	task automatic drain();
		rx_hold = 1'b1;
		while (board.due.size() != 0) @(negedge clk);
		rx_hold = 1'b0;
		repeat (20) @(negedge clk);
	endtask

	function bit [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		bit [63:0] ext[4];
		bit [255:0] ek, ik;
		int spoil;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = hsp_pkg::REG_ENC_W0;
		cfg_data = '0;
		in_valid = 1'b0;
		iv_high = '0;
		iv_low = '0;
		cipher_word = '0;
		tag_bytes = '0;
		rx_hold = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// zero keys straight out of reset
		ext = '{64'h0, '1, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff};
		send(64'h0, 64'h0, 64'h0, 32'h0, 0);
		send('1, '1, '1, '1, 0);
		for (int i = 0; i < 4; i++) send_price(ext[i], ext[3 - i], ext[i], 0, 0);
		send_price(rnd64(), rnd64(), rnd64(), 1, 1);
		send_price(rnd64(), rnd64(), rnd64(), 2, 0);
		drain();

		load_keys('1, '1);
		for (int i = 0; i < 4; i++) send_price(rnd64(), rnd64(), ext[i], 0, 0);
		send_price(rnd64(), rnd64(), 64'h1, 1, 0);
		send(rnd64(), rnd64(), rnd64(), $urandom, 2);
		drain();

		load_keys({4{64'h8000_0000_0000_0000}}, {4{64'h0000_0000_0000_0001}});
		for (int i = 0; i < 4; i++) send_price(ext[i], ext[i], ext[i], i % 3, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			ek = {rnd64(), rnd64(), rnd64(), rnd64()};
			ik = {rnd64(), rnd64(), rnd64(), rnd64()};
			if (ph == 4) ik = '0;
			if (ph == 5) ek = '1;
			load_keys(ek, ik);
			for (int n = 0; n < 85; n++) begin
				spoil = $urandom_range(0, 9);
				if (spoil < 6)
					send_price(rnd64(), rnd64(), rnd64(), 0, gap_len());
				else if (spoil < 8)
					send_price(rnd64(), rnd64(), rnd64(), $urandom_range(1, 2), gap_len());
				else
					send(rnd64(), rnd64(), rnd64(), $urandom, gap_len());
				if (n == 40) drain();
			end
			drain();
		end

		drain();
		repeat (700) @(negedge clk);
		$display("%0d tokens decrypted under 9 key settings, %0d with a valid signature",
			board.checked, board.good_tags);
		$display("%0d mismatches, %0d results left pending", board.errors, board.due.size());
		if (board.errors == 0 && board.due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/hsp_pkg.sv
hw/rtl/hsp_ctrl.sv
hw/rtl/hsp_datapath.sv
hw/rtl/hmac_sha1_price_decrypt.sv
dv/hmac_sha1_price_decrypt_test.sv
